[src/nrts_pkg.sv]
// Package: shared constants, types and helpers for the rotation table search
package nrts_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int MAX_REPORT   = 32;
    localparam int ELEMENT_BITS = 16;
    localparam int ELEMS        = 9;
    localparam int LANES        = 3;
    localparam int ELEM_PER_LN  = ELEMS / LANES;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int REP_W   = $clog2(MAX_REPORT + 1);
    localparam int POS_W   = (MAX_REPORT > 1) ? $clog2(MAX_REPORT) : 1;
    localparam int DIST_W  = 36;
    localparam int ENTRY_W = ELEMS * ELEMENT_BITS;
    localparam int DIFF_W  = ELEMENT_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int LSUM_W  = SQ_W + 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [REP_W-1:0]  REPORT_RESET = REP_W'(20);

    localparam int PADDR_W = 1;
    localparam logic [PADDR_W-1:0] REG_TABLE_COUNT  = 1'b0;
    localparam logic [PADDR_W-1:0] REG_REPORT_COUNT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [ELEMENT_BITS-1:0] t_elem;
    typedef t_elem [ELEMS-1:0] t_matrix;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        t_matrix           m;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  match_index;
        logic [DIST_W-1:0] distance_sq;
        logic              last_of_run;
        logic              table_empty;
    } t_rsp;

    // one distance candidate from the lane merge into the sorted list
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] dsq;
    } t_cand;

    function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] a,
                                                   logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] widen(logic [LSUM_W-1:0] v);
        if (LSUM_W > DIST_W) begin
            return (v > LSUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(v);
        end
        return DIST_W'(v);
    endfunction

endpackage

[src/nrts_if.sv]
// Valid/ready channel interface
interface nrts_if #(parameter type T = logic) (input logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/nrts_ram.sv]
// Generic single-port RAM with registered read
module nrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/nrts_lane.sv]
// Distance lane: squared differences over one row of the matrix
module nrts_lane (
    input  logic                                i_clk,
    input  logic [nrts_pkg::ELEM_PER_LN-1:0][nrts_pkg::ELEMENT_BITS-1:0] i_a,
    input  logic [nrts_pkg::ELEM_PER_LN-1:0][nrts_pkg::ELEMENT_BITS-1:0] i_b,
    output logic [nrts_pkg::LSUM_W-1:0]        o_sum
);
    import nrts_pkg::*;

    logic [ELEM_PER_LN-1:0][SQ_W-1:0] r_sq;
    logic [LSUM_W-1:0]                r_sum;
    logic [ELEM_PER_LN-1:0][SQ_W-1:0] n_sq;
    logic [LSUM_W-1:0]                n_sum;

    always_comb begin
        for (int k = 0; k < ELEM_PER_LN; k++) begin
            logic signed [DIFF_W-1:0] d;
            logic signed [SQ_W-1:0]   p;
            d = DIFF_W'($signed(i_a[k])) - DIFF_W'($signed(i_b[k]));
            // product sized by the assignment, operands sign-extended
            p = d * d;
            n_sq[k] = $unsigned(p);
        end
        n_sum = '0;
        for (int k = 0; k < ELEM_PER_LN; k++) begin
            n_sum = n_sum + LSUM_W'(r_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq  <= n_sq;
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;
endmodule

[src/nrts_merge.sv]
// Merge of lane sums and sorted insertion into the best list
module nrts_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [nrts_pkg::LANES-1:0][nrts_pkg::LSUM_W-1:0] i_lane_sum,
    input  logic                               i_valid,
    input  logic                               i_first,
    input  logic [nrts_pkg::IDX_W-1:0]         i_index,
    input  logic [nrts_pkg::REP_W-1:0]         i_limit,
    input  logic [nrts_pkg::POS_W-1:0]         i_rd_pos,
    output logic [nrts_pkg::IDX_W-1:0]         o_rd_index,
    output logic [nrts_pkg::DIST_W-1:0]        o_rd_dist,
    output logic [nrts_pkg::REP_W-1:0]         o_fill,
    output logic                               o_busy
);
    import nrts_pkg::*;

    t_cand r_cand;
    t_cand n_cand;
    logic [MAX_REPORT-1:0][IDX_W-1:0]  r_idx;
    logic [MAX_REPORT-1:0][DIST_W-1:0] r_dist;
    logic [REP_W-1:0]                  r_fill;
    logic [MAX_REPORT-1:0][IDX_W-1:0]  n_idx;
    logic [MAX_REPORT-1:0][DIST_W-1:0] n_dist;
    logic [REP_W-1:0]                  n_fill;

    always_comb begin
        logic [DIST_W-1:0] s;
        s = '0;
        for (int l = 0; l < LANES; l++) begin
            s = sat_add(s, widen(i_lane_sum[l]));
        end
        n_cand = '{valid: i_valid, first: i_first, index: i_index, dsq: s};
    end

    // insertion: entries with dist > cand shift one place down
    always_comb begin
        logic [REP_W-1:0] fill;
        logic [MAX_REPORT-1:0] gt;
        logic drop;
        fill = r_cand.first ? '0 : r_fill;
        n_idx  = r_idx;
        n_dist = r_dist;
        n_fill = fill;
        drop = 1'b0;
        for (int p = 0; p < MAX_REPORT; p++) begin
            gt[p] = (REP_W'(p) < fill) && (r_dist[p] > r_cand.dsq);
        end
        if (fill >= i_limit) begin
            drop = !(r_cand.dsq < r_dist[POS_W'(i_limit - REP_W'(1))]);
        end
        if (r_cand.valid && !drop) begin
            for (int p = 0; p < MAX_REPORT; p++) begin
                if (gt[p]) begin
                    if (p > 0 && !gt[p-1]) begin
                        n_idx[p]  = r_cand.index;
                        n_dist[p] = r_cand.dsq;
                    end else if (p == 0) begin
                        n_idx[p]  = r_cand.index;
                        n_dist[p] = r_cand.dsq;
                    end
                    if (p + 1 < MAX_REPORT) begin
                        n_idx[(p+1) % MAX_REPORT]  = r_idx[p];
                        n_dist[(p+1) % MAX_REPORT] = r_dist[p];
                    end
                end else if (REP_W'(p) == fill && (p == 0 || !gt[(p+MAX_REPORT-1)
                             % MAX_REPORT])) begin
                    n_idx[p]  = r_cand.index;
                    n_dist[p] = r_cand.dsq;
                end
            end
            n_fill = (fill >= i_limit) ? i_limit : fill + REP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
            r_cand.first <= 1'b0;
            r_fill <= '0;
        end else begin
            r_cand <= n_cand;
            r_fill <= n_fill;
        end
        r_idx  <= n_idx;
        r_dist <= n_dist;
    end

    assign o_rd_index = r_idx[i_rd_pos];
    assign o_rd_dist  = r_dist[i_rd_pos];
    assign o_fill     = r_fill;
    assign o_busy     = r_cand.valid;

`ifndef SYNTHESIS
    a_fill_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= REP_W'(MAX_REPORT)) else $error("best list overfilled");
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill > REP_W'(1)) |-> (r_dist[0] <= r_dist[1]))
        else $error("best list out of order");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_cand.valid && !$past(r_cand.valid)) |=> $stable(r_fill))
        else $error("fill moved without candidate");
`endif
endmodule

[src/nearest_rotation_table_search.sv]
// Top level: table load, lane-parallel distance scan and result emission
//
//  channel | dir | payload
//  in      | in  | mode, entry_index, m00..m22
//  out     | out | match_index, distance_sq, last_of_run, table_empty
//  cfg     | in  | APB: table_count @0x0, report_count @0x4
//
// Load: the result is offered in the cycle after the request is taken.
// Query: the first result is offered after the table scan (one table RAM read a cycle,
// RAM latency, two lane stages, merge/insert, drain), then one result per cycle as the
// sink takes them. One request in flight at a time.
// Reset is synchronous; i_rst_n low clears control state and valid flags, table_count to 0, report_count to 20.
// Output stalls hold the emit counter; the input is not taken until done.
module nearest_rotation_table_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nrts_if.sink                          i_req,
    nrts_if.source                        o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrts_pkg::PADDR_W+1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import nrts_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT, S_ACK} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_table_count;
    logic [REP_W-1:0] r_report_count;
    logic [CNT_W-1:0] r_scan_cnt;
    logic [CNT_W-1:0] r_scan_len;
    logic [REP_W-1:0] r_limit;
    logic [2:0]       r_drain;
    logic [REP_W-1:0] r_emit;
    logic             r_empty;
    t_matrix          r_target;
    logic [IDX_W-1:0] r_ack_idx;
    logic             r_rd_v, r_rd_v2;
    logic             r_rd_f, r_rd_f2;
    logic [IDX_W-1:0] r_rd_i, r_rd_i2;

    logic                          wr;
    logic [PADDR_W-1:0]            reg_sel;
    logic [ENTRY_W-1:0]            ram_rd;
    logic [ENTRY_W-1:0]            ram_wd;
    logic [IDX_W-1:0]              ram_addr;
    logic                          ram_we;
    logic [LANES-1:0][LSUM_W-1:0]  lane_sum;
    logic [IDX_W-1:0]              b_idx;
    logic [DIST_W-1:0]             b_dist;
    logic [REP_W-1:0]              b_fill;
    logic                          m_busy;
    logic                          scan_go;
    t_matrix                       ent;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W+1:2];
    assign wr      = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_comb begin
        unique case (reg_sel)
            REG_TABLE_COUNT:  prdata = 32'(r_table_count);
            REG_REPORT_COUNT: prdata = 32'(r_report_count);
            default:          prdata = '0;
        endcase
    end

    assign ram_we   = i_req.valid && i_req.ready && (i_req.data.mode == MODE_LOAD);
    assign ram_wd   = ENTRY_W'(i_req.data.m);
    assign scan_go  = (r_state == S_SCAN) && (r_scan_cnt < r_scan_len);
    assign ram_addr = ram_we ? i_req.data.entry_index : IDX_W'(r_scan_cnt);
    assign ent      = t_matrix'(ram_rd);

    nrts_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        nrts_lane u_lane (
            .i_clk(i_clk),
            .i_a  (r_target[l*ELEM_PER_LN +: ELEM_PER_LN]),
            .i_b  (ent[l*ELEM_PER_LN +: ELEM_PER_LN]),
            .o_sum(lane_sum[l])
        );
    end

    nrts_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lane_sum(lane_sum),
        .i_valid   (r_rd_v2),
        .i_first   (r_rd_f2),
        .i_index   (r_rd_i2),
        .i_limit   (r_limit),
        .i_rd_pos  (POS_W'(r_emit)),
        .o_rd_index(b_idx),
        .o_rd_dist (b_dist),
        .o_fill    (b_fill),
        .o_busy    (m_busy)
    );

    // RAM read then two lane stages before the merge sees a candidate
    logic r_rd_v1, r_rd_f1;
    logic [IDX_W-1:0] r_rd_i1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_table_count  <= '0;
            r_report_count <= REPORT_RESET;
            r_rd_v  <= 1'b0;
            r_rd_v1 <= 1'b0;
            r_rd_v2 <= 1'b0;
            r_rd_f  <= 1'b0;
            r_rd_f1 <= 1'b0;
            r_rd_f2 <= 1'b0;
            r_scan_cnt <= '0;
            r_emit  <= '0;
            r_drain <= '0;
        end else begin
            if (wr) begin
                unique case (reg_sel)
                    REG_TABLE_COUNT:  r_table_count  <= pwdata[CNT_W-1:0];
                    REG_REPORT_COUNT: r_report_count <= pwdata[REP_W-1:0];
                    default: ;
                endcase
            end
            r_rd_v  <= scan_go;
            r_rd_f  <= scan_go && (r_scan_cnt == '0);
            r_rd_i  <= IDX_W'(r_scan_cnt);
            r_rd_v1 <= r_rd_v;
            r_rd_f1 <= r_rd_f;
            r_rd_i1 <= r_rd_i;
            r_rd_v2 <= r_rd_v1;
            r_rd_f2 <= r_rd_f1;
            r_rd_i2 <= r_rd_i1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_target  <= i_req.data.m;
                        r_ack_idx <= i_req.data.entry_index;
                        if (i_req.data.mode == MODE_LOAD) begin
                            r_empty <= 1'b0;
                            r_state <= S_ACK;
                        end else begin
                            r_scan_len <= (r_table_count > CNT_W'(TABLE_DEPTH)) ?
                                          CNT_W'(TABLE_DEPTH) : r_table_count;
                            r_limit <= (r_report_count == '0) ? REP_W'(1) :
                                       (r_report_count > REP_W'(MAX_REPORT)) ?
                                       REP_W'(MAX_REPORT) : r_report_count;
                            r_empty    <= (r_table_count == '0);
                            r_scan_cnt <= '0;
                            r_state    <= (r_table_count == '0) ? S_ACK : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_scan_cnt <= r_scan_cnt + CNT_W'(1);
                    end else begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 3'd1;
                    if (r_drain == 3'd4) begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_rsp.ready) begin
                        r_emit <= r_emit + REP_W'(1);
                        if (r_emit + REP_W'(1) == b_fill) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ACK: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        o_rsp.valid = (r_state == S_EMIT) || (r_state == S_ACK);
        o_rsp.data  = '0;
        if (r_state == S_ACK) begin
            o_rsp.data.match_index = r_empty ? '0 : r_ack_idx;
            o_rsp.data.last_of_run = 1'b1;
            o_rsp.data.table_empty = r_empty;
        end else begin
            o_rsp.data.match_index = b_idx;
            o_rsp.data.distance_sq = b_dist;
            o_rsp.data.last_of_run = (r_emit + REP_W'(1) == b_fill);
        end
    end

`ifndef SYNTHESIS
    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !m_busy) else $error("emit during merge");
    a_emit_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit < b_fill)) else $error("emit past fill");
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready) else $error("second request");
`endif
endmodule
